/* design/rpn_pkg.sv */
// Shared types and codes for the RPN stack calculator.
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;

    // Operation codes carried on func
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Error codes reported with each result
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_DIVZERO   = 2'd2;
    localparam logic [1:0] ERR_FULL      = 2'd3;

    // Kind of stack update applied at commit
    typedef enum logic [1:0] {
        WB_NONE,
        WB_PUSH,
        WB_POP
    } wb_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     latch_in;
        logic     rd;
        logic     start;
        logic     step;
        logic     commit;
        wb_kind_t kind;
        logic [1:0] err;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] func;
        logic       full;
        logic       lt2;
        logic       top_zero;
        logic       calc_done;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

/* design/rpn_ctrl.sv */
// Sequencing state machine for the RPN stack calculator.
`timescale 1ns / 1ps
`default_nettype none
module rpn_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rpn_pkg::status_t status,
    output rpn_pkg::cmd_t        cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    rpn_pkg::wb_kind_t kind_reg, kind_next;
    logic [1:0]        err_reg, err_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        err_next     = err_reg;
        cmd          = '0;
        cmd.kind     = kind_reg;
        cmd.err      = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                kind_next  = rpn_pkg::WB_NONE;
                err_next   = rpn_pkg::ERR_OK;
                state_next = S_DONE;
                priority if (status.func == rpn_pkg::OP_PUSH)
                begin
                    if (status.full)
                        err_next = rpn_pkg::ERR_FULL;
                    else
                        kind_next = rpn_pkg::WB_PUSH;
                end
                else if (status.func == rpn_pkg::OP_ADD || status.func == rpn_pkg::OP_SUB ||
                         status.func == rpn_pkg::OP_MUL || status.func == rpn_pkg::OP_DIV)
                begin
                    if (status.lt2)
                        err_next = rpn_pkg::ERR_UNDERFLOW;
                    else if (status.func == rpn_pkg::OP_DIV && status.top_zero)
                        err_next = rpn_pkg::ERR_DIVZERO;
                    else
                    begin
                        kind_next  = rpn_pkg::WB_POP;
                        cmd.rd     = 1'b1;
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    // unused codes leave the stack alone
                    kind_next = rpn_pkg::WB_NONE;
                end
            end
            S_LOAD:
            begin
                cmd.start  = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (status.calc_done)
                    state_next = S_DONE;
                else
                    cmd.step = 1'b1;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= rpn_pkg::WB_NONE;
            err_reg   <= rpn_pkg::ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

/* design/rpn_dp.sv */
// Stack storage, iterative arithmetic and output register of the RPN calculator.
`timescale 1ns / 1ps
`default_nettype none
module rpn_dp #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] push_value,
    input  wire rpn_pkg::cmd_t      cmd,
    output rpn_pkg::status_t        status,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      top_value,
    output logic [4:0]              stack_depth,
    output logic [1:0]              error_code
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int NW = $clog2(DATA_WIDTH + 1);

    // Request and stack registers
    logic [2:0]    func_reg;
    logic [DW-1:0] pv_reg;
    logic [DW-1:0] top_reg, top_next;
    logic [CW-1:0] count_reg, count_next;
    logic [DW-1:0] mem [STACK_DEPTH];
    logic [DW-1:0] rd_reg;

    // Arithmetic unit registers
    logic [DW-1:0] acc_reg;
    logic [DW-1:0] addend_reg;
    logic [DW-1:0] shf_reg;
    logic [NW-1:0] iter_reg;
    logic          neg_reg;

    // Output register
    logic              out_valid_reg;
    logic signed [31:0] top_out_reg;
    logic [4:0]        depth_reg;
    logic [1:0]        err_out_reg;

    logic [DW+31:0] pv_ext;
    logic [CW-1:0]  wr_ptr, rd_ptr;
    logic [DW-1:0]  mag_a, mag_b, result, q_neg;
    logic [DW:0]    rem_sh, diff;
    logic [DW-1:0]  top_shown;
    logic [DW+31:0] top_ext;
    logic [CW+4:0]  depth_ext;

    assign pv_ext = {{DW{push_value[31]}}, push_value};
    assign wr_ptr = count_reg - CW'(1);
    assign rd_ptr = count_reg - CW'(2);

    // Status for the controller
    assign status.func      = func_reg;
    assign status.full      = (count_reg == CW'(STACK_DEPTH));
    assign status.lt2       = (count_reg < CW'(2));
    assign status.top_zero  = (top_reg == '0);
    assign status.calc_done = (iter_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg <= func;
            pv_reg   <= pv_ext[DW-1:0];
        end
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && cmd.kind == rpn_pkg::WB_PUSH && count_reg != '0)
            mem[wr_ptr[AW-1:0]] <= top_reg;
        if (cmd.rd)
            rd_reg <= mem[rd_ptr[AW-1:0]];
    end

    // Operand magnitudes for the divider
    assign mag_a = rd_reg[DW-1] ? (DW'(0) - rd_reg) : rd_reg;
    assign mag_b = top_reg[DW-1] ? (DW'(0) - top_reg) : top_reg;

    // Restoring divide step
    assign rem_sh = {acc_reg, shf_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, addend_reg};

    // Shift-add multiply, restoring divide, and add and subtract done at start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (cmd.start)
        begin
            unique case (func_reg)
                rpn_pkg::OP_MUL:
                begin
                    acc_reg    <= '0;
                    addend_reg <= rd_reg;
                    shf_reg    <= top_reg;
                    iter_reg   <= NW'(DATA_WIDTH);
                end
                rpn_pkg::OP_DIV:
                begin
                    acc_reg    <= '0;
                    addend_reg <= mag_b;
                    shf_reg    <= mag_a;
                    neg_reg    <= rd_reg[DW-1] ^ top_reg[DW-1];
                    iter_reg   <= NW'(DATA_WIDTH);
                end
                rpn_pkg::OP_SUB:
                begin
                    acc_reg  <= rd_reg - top_reg;
                    iter_reg <= '0;
                end
                default:
                begin
                    acc_reg  <= rd_reg + top_reg;
                    iter_reg <= '0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            iter_reg <= iter_reg - NW'(1);
            if (func_reg == rpn_pkg::OP_DIV)
            begin
                if (!diff[DW])
                begin
                    acc_reg <= diff[DW-1:0];
                    shf_reg <= {shf_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= rem_sh[DW-1:0];
                    shf_reg <= {shf_reg[DW-2:0], 1'b0};
                end
            end
            else
            begin
                if (shf_reg[0])
                    acc_reg <= acc_reg + addend_reg;
                addend_reg <= {addend_reg[DW-2:0], 1'b0};
                shf_reg    <= {1'b0, shf_reg[DW-1:1]};
            end
        end
    end

    // Final result with quotient sign fixup
    assign q_neg  = DW'(0) - shf_reg;
    assign result = (func_reg == rpn_pkg::OP_DIV) ? (neg_reg ? q_neg : shf_reg) : acc_reg;

    // Stack update at commit
    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        if (cmd.commit)
        begin
            unique case (cmd.kind)
                rpn_pkg::WB_PUSH:
                begin
                    top_next   = pv_reg;
                    count_next = count_reg + CW'(1);
                end
                rpn_pkg::WB_POP:
                begin
                    top_next   = result;
                    count_next = count_reg - CW'(1);
                end
                default:
                begin
                    top_next   = top_reg;
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // Result register
    assign top_shown = (count_next == '0) ? '0 : top_next;
    assign top_ext   = {32'b0, top_shown};
    assign depth_ext = {5'b0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            top_out_reg <= top_ext[31:0];
            depth_reg   <= depth_ext[4:0];
            err_out_reg <= cmd.err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_out_reg;
    assign stack_depth = depth_reg;
    assign error_code  = err_out_reg;

endmodule
`default_nettype wire

/* design/rpn_stack_calculator_unit.sv */
// Top level of the RPN stack calculator: controller plus datapath.
//
// Usage: the input channel (in_valid/in_ready, func, push_value) takes one
// request at a time: a push of a signed value or an add, subtract, multiply
// or divide of the two top entries. The output channel (out_valid/out_ready,
// top_value, stack_depth, error_code) returns exactly one result per request.
// A push, an error or an unused code goes from decode straight to the commit
// of its result; add and subtract first pass through the operand load and
// calculate states; multiply and divide iterate in the calculate state on the
// one-bit-per-cycle shift-add and restoring divide unit. A new request is taken
// the cycle after the result is loaded, not before the last one has committed.
// The stack top sits in a register; the entries below it live in a memory
// with one registered read port, read once per operation.
// Reset clears the stack depth and the output valid; no clearing pass.
// When the receiver stalls, the result holds in the output register, the next
// request is still accepted and worked on, and it waits before its commit
// until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] push_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      top_value,
    output logic [4:0]              stack_depth,
    output logic [1:0]              error_code
);

    rpn_pkg::cmd_t    cmd;
    rpn_pkg::status_t status;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .push_value  (push_value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .top_value   (top_value),
        .stack_depth (stack_depth),
        .error_code  (error_code)
    );

endmodule
`default_nettype wire
